### sv/tls_app_record_detector_assert.svh
// Assertion macros shared by the record detector modules.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef TLS_APP_RECORD_DETECTOR_ASSERT_SVH
`define TLS_APP_RECORD_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define TLSARD_ASSERT_SAME(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("tlsard assertion failed");

// Next-cycle implication.
`define TLSARD_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("tlsard assertion failed");

`endif

### sv/tlsard_pkg.sv
// ---------------------------------------------------------------------------
// TLS record detector package
// Types, reason codes and record constants shared by the detector files.
// ---------------------------------------------------------------------------
package tlsard_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MINOR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd1;

	localparam logic [7:0]  MAX_MINOR_RESET  = 8'd3;
	localparam logic [15:0] MAX_LENGTH_RESET = 16'd16384;

	// Reason codes
	localparam logic [2:0] REASON_APP   = 3'd0;
	localparam logic [2:0] REASON_SHORT = 3'd1;
	localparam logic [2:0] REASON_MAJOR = 3'd2;
	localparam logic [2:0] REASON_MINOR = 3'd3;
	localparam logic [2:0] REASON_TYPE  = 3'd4;
	localparam logic [2:0] REASON_LONG  = 3'd5;
	localparam logic [2:0] REASON_NONE  = 3'd6;

	// Header byte positions
	localparam logic [2:0] POS_TYPE   = 3'd0;
	localparam logic [2:0] POS_MAJOR  = 3'd1;
	localparam logic [2:0] POS_MINOR  = 3'd2;
	localparam logic [2:0] POS_LEN_HI = 3'd3;
	localparam logic [2:0] POS_LEN_LO = 3'd4;

	localparam logic [2:0] HEADER_BYTES = 3'd5;
	localparam logic [7:0] TLS_MAJOR    = 8'd3;

	// Record content types
	localparam logic [7:0] TYPE_CCS       = 8'h14;
	localparam logic [7:0] TYPE_HANDSHAKE = 8'h16;
	localparam logic [7:0] TYPE_APP_DATA  = 8'h17;

	typedef struct packed {
		logic [7:0]  max_minor;
		logic [15:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} step_t;

	typedef struct packed {
		logic       is_app;
		logic [2:0] reason;
	} verdict_t;

endpackage

### sv/tlsard_if.sv
// ---------------------------------------------------------------------------
// TLS record detector channels
// Byte input, verdict output and configuration write channels.
// ---------------------------------------------------------------------------
interface tlsard_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last_byte;

	modport source (output valid, output payload_byte, output last_byte, input ready);
	modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface tlsard_verdict_if;
	logic       valid;
	logic       ready;
	logic       is_app;
	logic [2:0] reason;

	modport source (output valid, output is_app, output reason, input ready);
	modport sink   (input valid, input is_app, input reason, output ready);
endinterface

interface tlsard_cfg_if import tlsard_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/tlsard_parser.sv
// ---------------------------------------------------------------------------
// TLS record header walker
// Per-packet state and single-byte update of the record header walk.
// ---------------------------------------------------------------------------
`include "tls_app_record_detector_assert.svh"

module tlsard_parser import tlsard_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  step_t    step,
	output verdict_t verdict
);

	logic [2:0]  pos_q, pos_d;
	logic [15:0] skip_q, skip_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [7:0]  rtype_q, rtype_d;
	logic        decided_q, decided_d;
	logic [2:0]  why_q, why_d;
	logic [2:0]  count_q, count_d;
	logic [15:0] rec_len;

	assign rec_len = {len_hi_q, step.data};

	always_comb begin
		pos_d     = pos_q;
		skip_d    = skip_q;
		len_hi_d  = len_hi_q;
		rtype_d   = rtype_q;
		decided_d = decided_q;
		why_d     = why_q;
		count_d   = (count_q < HEADER_BYTES) ? count_q + 3'd1 : count_q;

		if (!decided_q) begin
			if (skip_q != 16'd0) begin
				skip_d = skip_q - 16'd1;
			end else begin
				case (pos_q)
					POS_MAJOR: begin
						if (step.data != TLS_MAJOR) begin
							decided_d = 1'b1;
							why_d     = REASON_MAJOR;
						end else begin
							pos_d = POS_MINOR;
						end
					end
					POS_MINOR: begin
						if (step.data > cfg.max_minor) begin
							decided_d = 1'b1;
							why_d     = REASON_MINOR;
						end else if (rtype_q == TYPE_APP_DATA) begin
							decided_d = 1'b1;
							why_d     = REASON_APP;
						end else if (rtype_q inside {[TYPE_CCS:TYPE_HANDSHAKE]}) begin
							pos_d = POS_LEN_HI;
						end else begin
							decided_d = 1'b1;
							why_d     = REASON_TYPE;
						end
					end
					POS_LEN_HI: begin
						len_hi_d = step.data;
						pos_d    = POS_LEN_LO;
					end
					POS_LEN_LO: begin
						if (rec_len > cfg.max_length) begin
							decided_d = 1'b1;
							why_d     = REASON_LONG;
						end else begin
							skip_d = rec_len;
							pos_d  = POS_TYPE;
						end
					end
					default: begin
						// type byte; stray positions restart here too
						rtype_d = step.data;
						pos_d   = POS_MAJOR;
					end
				endcase
			end
		end

		if (count_d < HEADER_BYTES) begin
			verdict.reason = REASON_SHORT;
		end else if (decided_d) begin
			verdict.reason = why_d;
		end else begin
			verdict.reason = REASON_NONE;
		end
		verdict.is_app = (verdict.reason == REASON_APP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_TYPE;
			skip_q    <= 16'd0;
			len_hi_q  <= 8'd0;
			rtype_q   <= 8'd0;
			decided_q <= 1'b0;
			why_q     <= REASON_NONE;
			count_q   <= 3'd0;
		end else if (step.valid) begin
			if (step.last) begin
				// end of packet: start the next one clean
				pos_q     <= POS_TYPE;
				skip_q    <= 16'd0;
				len_hi_q  <= 8'd0;
				rtype_q   <= 8'd0;
				decided_q <= 1'b0;
				why_q     <= REASON_NONE;
				count_q   <= 3'd0;
			end else begin
				pos_q     <= pos_d;
				skip_q    <= skip_d;
				len_hi_q  <= len_hi_d;
				rtype_q   <= rtype_d;
				decided_q <= decided_d;
				why_q     <= why_d;
				count_q   <= count_d;
			end
		end
	end

	`TLSARD_ASSERT_SAME(a_skip_at_type, clk, arst_n, skip_q != 16'd0, pos_q == POS_TYPE)
	`TLSARD_ASSERT_SAME(a_pos_range, clk, arst_n, 1'b1, pos_q <= POS_LEN_LO)
	`TLSARD_ASSERT_SAME(a_count_range, clk, arst_n, 1'b1, count_q <= HEADER_BYTES)

endmodule

### sv/tls_app_record_detector.sv
// ---------------------------------------------------------------------------
// TLS application record detector
// Walks TLS record headers in a TCP payload and flags application data.
// ---------------------------------------------------------------------------
// Usage:
//   payload : one TCP payload byte per transfer, last_byte on the packet's final byte.
//   verdict : one transfer per packet, carrying is_app and a reason code.
//   cfg     : register writes (index 0 max minor version, 1 max record length),
//             always ready; write only while no packet is in flight.
// Pipeline: a last byte is registered on its transfer, evaluated once it advances from
//   the input register, and its verdict is presented from the output register.
// Throughput: one byte per cycle unless a last byte waits on a full verdict slot;
//   the header walk is a single-byte state update from input to verdict register.
// Stall: while a verdict waits, non-last bytes keep flowing; a further last byte
//   holds in the input register and payload.ready drops until the verdict goes.
// Reset: clears the packet state, the pipeline and the verdict register and
//   restores the register defaults (minor 3, length 16384).
// ---------------------------------------------------------------------------
`include "tls_app_record_detector_assert.svh"

module tls_app_record_detector import tlsard_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	tlsard_byte_if.sink            payload,
	tlsard_verdict_if.source       verdict,
	tlsard_cfg_if.sink             cfg
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;
	step_t      step;
	verdict_t   result;
	logic       out_valid_q;
	verdict_t   out_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_minor  <= MAX_MINOR_RESET;
			cfg_q.max_length <= MAX_LENGTH_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MAX_MINOR:  cfg_q.max_minor  <= cfg.data[7:0];
				REG_MAX_LENGTH: cfg_q.max_length <= cfg.data;
				default: ;
			endcase
		end
	end

	// advance the byte unless it is a last byte and the verdict slot is full and not being taken
	assign adv           = valid_s1 && (!last_s1 || !out_valid_q || verdict.ready);
	assign payload.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (payload.ready) begin
			valid_s1 <= payload.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (payload.ready && payload.valid) begin
			byte_s1 <= payload.payload_byte;
			last_s1 <= payload.last_byte;
		end
	end

	assign step.valid = adv;
	assign step.data  = byte_s1;
	assign step.last  = last_s1;

	tlsard_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.step    (step),
		.verdict (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_q <= result;
		end
	end

	assign verdict.valid  = out_valid_q;
	assign verdict.is_app = out_q.is_app;
	assign verdict.reason = out_q.reason;

	`TLSARD_ASSERT_NEXT(a_last_loads, clk, arst_n, adv && last_s1, out_valid_q)
	`TLSARD_ASSERT_SAME(a_app_match, clk, arst_n, out_valid_q,
		out_q.is_app == (out_q.reason == REASON_APP))
	`TLSARD_ASSERT_SAME(a_reason_range, clk, arst_n, out_valid_q, out_q.reason <= REASON_NONE)
	`TLSARD_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv,
		valid_s1 && $stable(byte_s1) && $stable(last_s1))

endmodule
